@@ rtl/sso_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sso_pkg;

  // default sizes
  localparam int unsigned PHASE_BITS_DEF  = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned INC_W     = 32;
  localparam int unsigned GAIN_W    = 15;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_INC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd2;

  localparam logic [INC_W-1:0]  LEFT_INC_RST  = 32'd19685267;
  localparam logic [INC_W-1:0]  RIGHT_INC_RST = 32'd19774745;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 15'd3277;

  // polynomial fixed point, q.17
  localparam int unsigned FRAC   = 17;
  localparam int unsigned X_W    = FRAC + 1;
  localparam int unsigned OP_W   = 22;
  localparam int unsigned PROD_W = 2 * OP_W;

  localparam int C1 = 411433;
  localparam int C3 = 672874;
  localparam int C5 = 318281;
  localparam int C7 = 56839;

  // microcode fields
  typedef enum logic [1:0] {A_X, A_XX, A_ACC} asel_e;
  typedef enum logic [1:0] {B_X, B_C7, B_ACC, B_GAIN} bsel_e;
  typedef enum logic [1:0] {WB_NONE, WB_XX, WB_ACC, WB_OUT} wb_e;
  typedef enum logic [1:0] {K_ZERO, K_C5, K_NC3, K_C1} ksel_e;
  typedef enum logic {SEQ_NEXT, SEQ_CHAN} seq_e;

  typedef struct packed {
    logic  load_x;
    logic  mul_en;
    asel_e a_sel;
    bsel_e b_sel;
    wb_e   wb;
    ksel_e k_sel;
    logic  sub;
    seq_e  seq;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   chan;
  } seq_ctrl_t;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd12;

  localparam uword_t UW_IDLE = '{
    load_x: 1'b0, mul_en: 1'b0, a_sel: A_X, b_sel: B_X,
    wb: WB_NONE, k_sel: K_ZERO, sub: 1'b0, seq: SEQ_NEXT
  };

  // program for one channel, run once for left and once for right
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = UW_IDLE;
    case (step)
      4'd0: w.load_x = 1'b1;
      4'd1: begin
        w.mul_en = 1'b1; w.a_sel = A_X; w.b_sel = B_X;
      end
      4'd2: w.wb = WB_XX;
      4'd3: begin
        w.mul_en = 1'b1; w.a_sel = A_XX; w.b_sel = B_C7;
      end
      4'd4: begin
        w.wb = WB_ACC; w.k_sel = K_C5; w.sub = 1'b1;
      end
      4'd5: begin
        w.mul_en = 1'b1; w.a_sel = A_XX; w.b_sel = B_ACC;
      end
      4'd6: begin
        w.wb = WB_ACC; w.k_sel = K_NC3;
      end
      4'd7: begin
        w.mul_en = 1'b1; w.a_sel = A_XX; w.b_sel = B_ACC;
      end
      4'd8: begin
        w.wb = WB_ACC; w.k_sel = K_C1;
      end
      4'd9: begin
        w.mul_en = 1'b1; w.a_sel = A_X; w.b_sel = B_ACC;
      end
      4'd10: begin
        w.wb = WB_ACC; w.k_sel = K_ZERO;
      end
      4'd11: begin
        w.mul_en = 1'b1; w.a_sel = A_ACC; w.b_sel = B_GAIN;
      end
      4'd12: begin
        w.wb = WB_OUT; w.seq = SEQ_CHAN;
      end
      default: w = UW_IDLE;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sso_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sso_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               hold_i,
  output sso_pkg::seq_ctrl_t      ctrl_o,
  output logic                    busy_o,
  output logic                    done_o
);
  import sso_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              chan_q, chan_d;
  logic              busy_q, busy_d;
  uword_t            uw;

  // control word fetch
  always_comb begin
    uw = busy_q ? ucode_rom(step_q) : UW_IDLE;
  end

  assign ctrl_o.uw   = uw;
  assign ctrl_o.chan = chan_q;
  assign busy_o      = busy_q;
  assign done_o      = busy_q && (uw.seq == SEQ_CHAN) && chan_q && !hold_i;

  // step counter and end-of-channel jump
  always_comb begin
    step_d = step_q;
    chan_d = chan_q;
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      chan_d = 1'b0;
    end else if (busy_q) begin
      if (uw.seq == SEQ_CHAN) begin
        if (!chan_q) begin
          chan_d = 1'b1;
          step_d = '0;
        end else if (!hold_i) begin
          busy_d = 1'b0;
          step_d = '0;
          chan_d = 1'b0;
        end
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      chan_q <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      chan_q <= chan_d;
      busy_q <= busy_d;
    end
  end

  // step counter stays inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> step_q <= LAST_STEP)
    else $error("sequencer step out of program");

  // a finished sample pair only comes from the right channel pass
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_q && chan_q)
    else $error("done outside the right channel pass");

endmodule

`default_nettype wire

@@ rtl/sso_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sso_datapath #(
  parameter int unsigned PHASE_BITS  = sso_pkg::PHASE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = sso_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire sso_pkg::seq_ctrl_t            ctrl_i,
  input  wire logic [PHASE_BITS-1:0]         phase_l_i,
  input  wire logic [PHASE_BITS-1:0]         phase_r_i,
  input  wire logic [sso_pkg::GAIN_W-1:0]    gain_i,
  output logic signed [SAMPLE_BITS-1:0]      left_o,
  output logic signed [SAMPLE_BITS-1:0]      sample_o
);
  import sso_pkg::*;

  localparam int unsigned OUT_SHIFT = 33 - SAMPLE_BITS;
  localparam logic signed [PROD_W-1:0] S_HI =
    (PROD_W'(1) << (SAMPLE_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] S_LO = ~S_HI;

  logic signed [X_W-1:0]         x_q;
  logic signed [OP_W-1:0]        xx_q;
  logic signed [OP_W-1:0]        acc_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [SAMPLE_BITS-1:0] left_q;

  logic [PHASE_BITS-1:0]     phase_sel;
  logic [PHASE_BITS+X_W-1:0] phase_ext;
  logic [X_W-1:0]            phase_top;
  logic signed [X_W-1:0]     x_new;
  logic signed [OP_W-1:0]    a_op, b_op, k_val, wb_val;
  logic signed [PROD_W-1:0]  prod_full, scaled, out_s;

  // phase to x: top bits of the phase, offset by one half turn
  assign phase_sel = ctrl_i.chan ? phase_r_i : phase_l_i;
  assign phase_ext = {phase_sel, X_W'(0)};
  assign phase_top = phase_ext[PHASE_BITS+X_W-1 -: X_W];
  assign x_new     = $signed({~phase_top[X_W-1], phase_top[X_W-2:0]});

  // multiplier operand selection
  always_comb begin
    case (ctrl_i.uw.a_sel)
      A_X:     a_op = OP_W'(x_q);
      A_XX:    a_op = xx_q;
      A_ACC:   a_op = acc_q;
      default: a_op = '0;
    endcase
    case (ctrl_i.uw.b_sel)
      B_X:     b_op = OP_W'(x_q);
      B_C7:    b_op = OP_W'(C7);
      B_ACC:   b_op = acc_q;
      B_GAIN:  b_op = OP_W'($signed({1'b0, gain_i}));
      default: b_op = '0;
    endcase
  end

  assign prod_full = a_op * b_op;

  // writeback: constant plus or minus floored q.17 product
  assign scaled = prod_q >>> FRAC;

  always_comb begin
    case (ctrl_i.uw.k_sel)
      K_ZERO:  k_val = '0;
      K_C5:    k_val = OP_W'(C5);
      K_NC3:   k_val = OP_W'(-C3);
      K_C1:    k_val = OP_W'(C1);
      default: k_val = '0;
    endcase
    if (ctrl_i.uw.sub) begin
      wb_val = k_val - OP_W'(scaled);
    end else begin
      wb_val = k_val + OP_W'(scaled);
    end
  end

  // gain scaling and saturation
  assign out_s = prod_q >>> OUT_SHIFT;

  always_comb begin
    if (out_s > S_HI) begin
      sample_o = SAMPLE_BITS'(S_HI);
    end else if (out_s < S_LO) begin
      sample_o = SAMPLE_BITS'(S_LO);
    end else begin
      sample_o = SAMPLE_BITS'(out_s);
    end
  end

  assign left_o = left_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.uw.load_x) begin
      x_q <= x_new;
    end
    if (ctrl_i.uw.mul_en) begin
      prod_q <= prod_full;
    end
    if (ctrl_i.uw.wb == WB_XX) begin
      xx_q <= OP_W'(scaled);
    end
    if (ctrl_i.uw.wb == WB_ACC) begin
      acc_q <= wb_val;
    end
    if (ctrl_i.uw.wb == WB_OUT && !ctrl_i.chan) begin
      left_q <= sample_o;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stereo_sine_oscillator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stereo sine oscillator. Each transaction on the input channel with tick_i
// high advances the left and right phase accumulators by their increments and
// yields one stereo sample pair, computed from the new phases by an odd
// degree-7 polynomial in q.17 fixed point, scaled by output_gain (q0.15) and
// saturated. A transaction with tick_i low is accepted while idle and yields
// nothing. A tick occupies the block for the accept cycle, then 13 microcode
// steps per channel on one shared 22x22 multiplier, six dependent products per
// channel, each a multiply step followed by a writeback step. The finished
// pair sits in an output register, so the next tick is taken while it waits;
// only if that pair is still stalled when the following one is done does the
// block pause until it is taken. Configuration writes (index 0 left increment,
// 1 right increment, 2 gain) must be made by the user while idle; unchecked.
module stereo_sine_oscillator_unit #(
  parameter int unsigned PHASE_BITS  = sso_pkg::PHASE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = sso_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sso_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sso_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            tick_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        left_sample_o,
  output logic signed [SAMPLE_BITS-1:0]        right_sample_o
);
  import sso_pkg::*;

  logic [INC_W-1:0]      left_inc_q, right_inc_q;
  logic [GAIN_W-1:0]     gain_q;
  logic [PHASE_BITS-1:0] left_phase_q, right_phase_q;
  logic                  out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;

  logic      in_accept, start, hold, busy, done;
  seq_ctrl_t ctrl;
  logic signed [SAMPLE_BITS-1:0] left_res, sample;

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign start      = in_accept && tick_i;
  assign hold       = out_valid_q && out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_inc_q  <= LEFT_INC_RST;
      right_inc_q <= RIGHT_INC_RST;
      gain_q      <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LEFT_INC:  left_inc_q  <= cfg_data_i;
        REG_RIGHT_INC: right_inc_q <= cfg_data_i;
        REG_GAIN:      gain_q      <= cfg_data_i[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // phase accumulators, advanced on each tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_phase_q  <= '0;
      right_phase_q <= '0;
    end else if (start) begin
      left_phase_q  <= left_phase_q + PHASE_BITS'(left_inc_q);
      right_phase_q <= right_phase_q + PHASE_BITS'(right_inc_q);
    end
  end

  sso_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .hold_i  (hold),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .done_o  (done)
  );

  sso_datapath #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .phase_l_i (left_phase_q),
    .phase_r_i (right_phase_q),
    .gain_i    (gain_q),
    .left_o    (left_res),
    .sample_o  (sample)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_left_q  <= left_res;
      out_right_q <= sample;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = out_left_q;
  assign right_sample_o = out_right_q;

  // a tick transaction always starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni) start |=> in_stall_o)
    else $error("tick taken without starting the sequencer");

  // phases hold while a sample pair is being computed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(left_phase_q) && $stable(right_phase_q)))
    else $error("phase changed during computation");

  // a new pair never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !(out_valid_q && out_stall_i))
    else $error("pending sample pair overwritten");

endmodule

`default_nettype wire
